// File: src/radix_number_to_padded_text_assert.svh
// Assertion macros used by the checker of the radix text formatter.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef RADIX_NUMBER_TO_PADDED_TEXT_ASSERT_SVH
`define RADIX_NUMBER_TO_PADDED_TEXT_ASSERT_SVH

// Same-cycle implication.
`define RNPT_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RNPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rnpt_pkg.sv
`default_nettype none

package rnpt_pkg;

	// Field widths
	localparam int VALUE_W    = 16;
	localparam int BASE_W     = 6;
	localparam int PAD_W      = 6;
	localparam int CHAR_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// Default digit store depth
	localparam int DIGITS_DEF = 16;

	// Register limits and reset values
	localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
	localparam logic [BASE_W-1:0] BASE_RST  = 6'd10;
	localparam logic [PAD_W-1:0]  PAD_LIMIT = 6'd32;
	localparam logic [BASE_W-1:0] DEC_DIGITS = 6'd10;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE = 2'd0,
		REG_PAD  = 2'd1,
		REG_FILL = 2'd2
	} cfg_reg_t;

	// Divider request and result
	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [BASE_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] quot;
		logic [BASE_W-1:0]  rem;
	} div_res_t;

	// Digit value to ASCII: 0-9 then A onward
	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {{(CHAR_W-BASE_W){1'b0}}, d};
		if (d < DEC_DIGITS)
			return CHAR_ZERO + d_ext;
		return CHAR_A + d_ext - {{(CHAR_W-BASE_W){1'b0}}, DEC_DIGITS};
	endfunction

endpackage

`default_nettype wire

// File: src/rnpt_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module rnpt_div
	import rnpt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output      div_res_t res
);

	localparam int STEP_W = $clog2(VALUE_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [VALUE_W-1:0] quo_q;
	logic [BASE_W-1:0]  rem_q;
	logic [BASE_W-1:0]  divisor_q;

	logic [BASE_W:0]    trial;
	logic [BASE_W:0]    diff;
	logic               ge;
	logic [BASE_W-1:0]  rem_next;

	// Shift in next dividend bit, subtract when it fits
	always_comb begin
		trial    = {rem_q, quo_q[VALUE_W-1]};
		diff     = trial - {1'b0, divisor_q};
		ge       = (trial >= {1'b0, divisor_q});
		rem_next = ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

`default_nettype wire

// File: src/radix_number_to_padded_text.sv
// Radix text formatter: turns an unsigned 16-bit value into ASCII text.
// Config: write digit_base (index 0), pad_width (1), zero_fill (2) on the
// cfg channel while the block is idle; cfg_ready is always high.
// Input: value is taken when in_valid is high and in_stall is low. in_stall
// stays high from the cycle after a value is taken until its last character
// has been loaded into the output register.
// Output: one character per word, fill characters first, then digits most
// significant first; last marks the final character of the number.
// Digits: each digit comes from a bit-serial divider shared by all digits,
// in these steps: start, 16 shift/subtract steps, result pickup.
// After that, characters go out one per cycle while out_stall is low.
// A stalled output word holds; the sequencer waits until it is taken.
// Reset: returns registers to base 10, no padding, space fill, and idle.
`default_nettype none

module radix_number_to_padded_text
	import rnpt_pkg::*;
#(
	parameter int MAX_DIGITS = DIGITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic [VALUE_W-1:0]    value,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [CHAR_W-1:0]     character,
	output      logic                  last
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_FILL  = 5'b01000,
		ST_DIGIT = 5'b10000
	} state_t;

	state_t             state_q;
	logic [BASE_W-1:0]  base_q;
	logic [PAD_W-1:0]   pad_q;
	logic               zero_fill_q;
	logic [VALUE_W-1:0] n_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   dig_q;
	logic [PAD_W-1:0]   fill_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic [BASE_W-1:0]  digit_q [MAX_DIGITS];

	logic [BASE_W-1:0]  base_eff;
	logic [PAD_W-1:0]   pad_eff;
	logic [CNT_W-1:0]   cnt_nxt;
	logic [PAD_W:0]     pad_ext;
	logic [PAD_W:0]     cnt_ext;
	logic [PAD_W-1:0]   fill_cnt;
	logic               out_free;
	logic [CHAR_W-1:0]  fill_char;
	div_req_t           div_req;
	div_res_t           div_res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RST;
			pad_q       <= '0;
			zero_fill_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASE: base_q      <= cfg_data[BASE_W-1:0];
				REG_PAD:  pad_q       <= cfg_data[PAD_W-1:0];
				REG_FILL: zero_fill_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// Clamp radix and pad width; fill count from digit count
	always_comb begin
		if (base_q < BASE_MIN)
			base_eff = BASE_MIN;
		else if (base_q > BASE_MAX)
			base_eff = BASE_MAX;
		else
			base_eff = base_q;
		pad_eff   = (pad_q > PAD_LIMIT) ? PAD_LIMIT : pad_q;
		cnt_nxt   = (cnt_q < CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		pad_ext   = {1'b0, pad_eff} + 1'b1;
		cnt_ext   = (PAD_W+1)'(cnt_nxt);
		fill_cnt  = (pad_ext > cnt_ext) ? PAD_W'(pad_ext - cnt_ext) : '0;
		fill_char = zero_fill_q ? CHAR_ZERO : CHAR_SPACE;
	end

	// Shared divider
	assign div_req.start    = (state_q == ST_LOAD);
	assign div_req.dividend = n_q;
	assign div_req.divisor  = base_eff;

	rnpt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			dig_q   <= '0;
			fill_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_res.done) begin
						cnt_q <= cnt_nxt;
						if (div_res.quot == '0) begin
							fill_q  <= fill_cnt;
							dig_q   <= IDX_W'(cnt_nxt - 1'b1);
							state_q <= (fill_cnt != '0) ? ST_FILL : ST_DIGIT;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_FILL: begin
					if (out_free) begin
						fill_q <= fill_q - 1'b1;
						if (fill_q == PAD_W'(1))
							state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_free) begin
						if (dig_q == '0)
							state_q <= ST_IDLE;
						else
							dig_q <= dig_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working value and digit store
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			n_q <= value;
		else if (state_q == ST_WAIT && div_res.done)
			n_q <= div_res.quot;
		if (state_q == ST_WAIT && div_res.done && cnt_q < CNT_MAX)
			digit_q[cnt_q[IDX_W-1:0]] <= div_res.rem;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && (state_q == ST_FILL || state_q == ST_DIGIT)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_FILL) begin
			char_q <= fill_char;
			last_q <= 1'b0;
		end else if (out_free && state_q == ST_DIGIT) begin
			char_q <= digit_char(digit_q[dig_q]);
			last_q <= (dig_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// File: src/rnpt_checker.sv
`default_nettype none

`include "radix_number_to_padded_text_assert.svh"

// Port-level checks on the radix text formatter
module rnpt_checker
	import rnpt_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [CHAR_W-1:0] character,
	input wire logic              last
);

	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;

	logic              in_take;
	logic              out_take;
	logic              out_held;
	logic [CHAR_W:0]   out_word;
	logic              char_ok;

	// Handshake terms and the visible output word
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign out_held = out_valid && out_stall;
	assign out_word = {character, last};

	// Fill characters and digits 0-9, A-Z
	assign char_ok = (character == CHAR_SPACE)
		|| (character >= CHAR_ZERO && character <= CHAR_NINE)
		|| (character >= CHAR_A && character <= CHAR_Z);

	// A stalled word holds
	`RNPT_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "held word changed")

	// Taking a value starts a conversion, so the input side stalls
	`RNPT_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "input not stalled after a take")

	// Only fill and digit characters come out
	`RNPT_ASSERT_IMPLY(a_char_set, out_valid, char_ok, "character outside fill and digit set")

	// Characters of one number follow without gaps
	`RNPT_ASSERT_NEXT(a_no_gap, out_take && !last, out_valid, "gap inside a number")

endmodule

bind radix_number_to_padded_text rnpt_checker u_rnpt_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import rnpt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 500;
	localparam int SETTLE_CYCLES = 400;
	localparam int REPORT_MAX = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// One output word: a character and its end-of-number flag
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_word_t;

	// Predicts the text of each accepted value and checks the output words against it
	class text_checker;
		logic [BASE_W-1:0] base_reg;
		logic [PAD_W-1:0]  pad_reg;
		logic              fill_reg;
		char_word_t        expected_text[$];
		int                bad_chars;

		function new();
			base_reg = BASE_RST;
			pad_reg = '0;
			fill_reg = 1'b0;
			bad_chars = 0;
		endfunction

		// Mirror of a register write; unknown indexes leave everything alone
		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BASE: base_reg = data[BASE_W-1:0];
				REG_PAD:  pad_reg = data[PAD_W-1:0];
				REG_FILL: fill_reg = data[0];
				default: ;
			endcase
		endfunction

		// Expected characters for one accepted value
		function void note_value(logic [VALUE_W-1:0] v);
			int radix;
			int width;
			int n;
			int fills;
			int digs[$];
			char_word_t w;
			radix = int'(base_reg);
			if (radix < int'(BASE_MIN)) radix = int'(BASE_MIN);
			if (radix > int'(BASE_MAX)) radix = int'(BASE_MAX);
			width = (pad_reg > PAD_LIMIT) ? int'(PAD_LIMIT) : int'(pad_reg);
			// digits come out least significant first, so build the list from the front
			n = int'(v);
			do begin
				digs.push_front(n % radix);
				n = n / radix;
			end while (n > 0);
			fills = (width + 1 > digs.size()) ? width + 1 - digs.size() : 0;
			for (int i = 0; i < fills; i++) begin
				w.ch = fill_reg ? CHAR_ZERO : CHAR_SPACE;
				w.last = 1'b0;
				expected_text.push_back(w);
			end
			for (int i = 0; i < digs.size(); i++) begin
				if (digs[i] < int'(DEC_DIGITS))
					w.ch = CHAR_ZERO + 8'(digs[i]);
				else
					w.ch = CHAR_A + 8'(digs[i] - int'(DEC_DIGITS));
				w.last = (i == digs.size() - 1);
				expected_text.push_back(w);
			end
		endfunction

		// Compare one output word with the oldest expected character
		function void check_char(logic [CHAR_W-1:0] ch, logic lst);
			char_word_t w;
			if (expected_text.size() == 0) begin
				bad_chars++;
				if (bad_chars <= REPORT_MAX)
					$display("unexpected word: char %h last %b (nothing expected)", ch, lst);
			end else begin
				w = expected_text.pop_front();
				if (w.ch !== ch || w.last !== lst) begin
					bad_chars++;
					if (bad_chars <= REPORT_MAX)
						$display("mismatch: expected char %h last %b, got char %h last %b",
							w.ch, w.last, ch, lst);
				end
			end
		endfunction

		function int pending();
			return expected_text.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [VALUE_W-1:0]    value;
	logic                  out_valid;
	logic                  out_stall;
	logic [CHAR_W-1:0]     character;
	logic                  last;

	text_checker sb;
	int send_idle_pct;
	int stall_pct;
	int hold_left;
	logic hold_req;
	int cycle_count;

	radix_number_to_padded_text dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Output side: check accepted words
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_char(character, last);
	end

	// Receiver stall: random, plus a long hold-off counted here
	always @(posedge clk) begin
		if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		out_stall <= hold_req || (hold_left > 1) || ($urandom_range(0, 99) < stall_pct);
	end

	// Offer one value, with a random gap first; valid stays high for the next call
	task automatic send_value(input logic [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_value(v);
	endtask

	// Stop offering and wait until every expected character has come out
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// One register write; valid stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] pad,
			input logic [CFG_DATA_W-1:0] fill);
		wait_drain();
		write_reg(REG_BASE, base);
		write_reg(REG_PAD, pad);
		write_reg(REG_FILL, fill);
		cfg_valid <= 1'b0;
	endtask

	// Random phase: two blocks of values, each under a fresh random setting
	task automatic run_phase(input int n_items, input int idle, input int stall);
		int r;
		logic [VALUE_W-1:0] v;
		send_idle_pct = idle;
		stall_pct <= stall;
		for (int blk = 0; blk < 2; blk++) begin
			r = $urandom_range(0, 9);
			configure((r == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(2, 36)),
				(r == 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 6)),
				6'($urandom));
			for (int i = 0; i < n_items / 2; i++) begin
				case ($urandom_range(0, 3))
					0: v = 16'($urandom_range(0, 15));
					1: v = 16'($urandom_range(0, 999));
					default: v = 16'($urandom);
				endcase
				send_value(v);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE;
		cfg_data = '0;
		in_valid = 1'b0;
		value = '0;
		out_stall = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: decimal, no padding
		send_value(16'd0);
		send_value(16'hFFFF);
		send_value(16'd1);
		send_value(16'd9);
		send_value(16'd10);

		// Radix below two acts as binary
		configure(6'd0, 6'd0, 6'h01);
		send_value(16'hFFFF);
		send_value(16'd0);
		send_value(16'h8000);

		// Radix and pad above their limits, space fill
		configure(6'd63, 6'd63, 6'h00);
		send_value(16'd35);
		send_value(16'd0);
		send_value(16'hFFFF);

		// Top radix, widest pad, zero fill with the upper data bits set
		configure(6'd36, 6'd32, 6'h3F);
		send_value(16'd0);
		send_value(16'd12345);

		// Radix one, fill bit clear under set upper bits
		configure(6'd1, 6'd15, 6'h3E);
		send_value(16'h5555);
		send_value(16'd1);

		// Unknown register index must change nothing
		wait_drain();
		write_reg(REG_UNUSED, 6'h3F);
		cfg_valid <= 1'b0;
		send_value(16'h00FF);

		// Hex with zero fill
		configure(6'd16, 6'd3, 6'h01);
		send_value(16'hABCD);
		send_value(16'h00FF);
		send_value(16'h000F);

		// Just past the limits
		configure(6'd37, 6'd33, 6'h01);
		send_value(16'h7FFF);

		configure(6'd10, 6'd5, 6'h01);
		send_value(16'd42);
		send_value(16'hFFFF);

		// Random phases with different idling
		run_phase(18, 0, 0);
		run_phase(18, 80, 0);
		run_phase(18, 0, 80);
		run_phase(18, 37, 37);

		// Long receiver hold-off while values keep coming
		configure(6'd10, 6'd4, 6'h00);
		send_idle_pct = 0;
		stall_pct <= 0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		for (int i = 0; i < 6; i++)
			send_value(16'($urandom));

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.bad_chars == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: radix_number_to_padded_text.f
+incdir+src
src/rnpt_pkg.sv
src/rnpt_div.sv
src/radix_number_to_padded_text.sv
src/rnpt_checker.sv
tb/sv/tb.sv
